@@ rtl/core/i2cmbe_pkg.sv @@
// Package for the I2C master byte engine: command codes, bus phase constants
// and the per-command phase count. No dependencies.
package i2cmbe_pkg;

	// Command codes as carried on req_type; IDLE also marks "no command running".
	typedef enum logic [2:0] {
		CMD_IDLE      = 3'd0,
		CMD_START     = 3'd1,
		CMD_STOP      = 3'd2,
		CMD_WRITE     = 3'd3,
		CMD_READ_ACK  = 3'd4,
		CMD_READ_NACK = 3'd5
	} cmd_t;

	localparam int unsigned PHASE_W = 5;
	localparam int unsigned TICK_W  = 10;
	localparam int unsigned BYTE_W  = 8;

	// Phase counts per command.
	localparam logic [PHASE_W-1:0] PH_TOTAL_SHORT = 5'd3;
	localparam logic [PHASE_W-1:0] PH_TOTAL_WRITE = 5'd27;
	localparam logic [PHASE_W-1:0] PH_TOTAL_READ  = 5'd19;

	// Landmark phases of the write and read sequences.
	localparam logic [PHASE_W-1:0] PH_WR_ACK_REL  = 5'd24;
	localparam logic [PHASE_W-1:0] PH_WR_ACK_SAMP = 5'd25;
	localparam logic [PHASE_W-1:0] PH_RD_ACK_DRV  = 5'd16;
	localparam logic [PHASE_W-1:0] PH_RD_ACK_CLK  = 5'd17;

	localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 10'd5;
	localparam logic [2:0]        MSB_BIT         = 3'd7;
	localparam logic [1:0]        SUB_LAST        = 2'd2;

	// Number of bus phases a command runs.
	function automatic logic [PHASE_W-1:0] phase_total(input cmd_t cmd);
		logic [PHASE_W-1:0] total;
		unique case (cmd)
			CMD_START, CMD_STOP: total = PH_TOTAL_SHORT;
			CMD_WRITE:           total = PH_TOTAL_WRITE;
			default:             total = PH_TOTAL_READ;
		endcase
		return total;
	endfunction

endpackage

@@ rtl/core/i2c_master_byte_engine_top.sv @@
// I2C master byte engine: one item per tick, result registered after accept.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per clock but for out_ready stalls; output refilled while read.
// The sequencer updates once per accepted item and finishes a command of P
// phases after P * phase_ticks items (zero counts as one). Reset: idle,
// SCL and SDA released, ACK 1, read byte 0, phase_ticks 5, no result pending.
module i2c_master_byte_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] phase_ticks,
	// Input item channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] req_type,
	input  logic [7:0] write_byte,
	input  logic       sda_in,
	// Result item channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_hiz,
	output logic       sda_hiz,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_byte,
	output logic       ack_bit
);

	// Sequencer state.
	i2cmbe_pkg::cmd_t                          cmd_q, cmd_n;
	logic [i2cmbe_pkg::PHASE_W-1:0]            phase_q, phase_n;
	logic [i2cmbe_pkg::TICK_W-1:0]             tick_q, tick_n;
	logic [1:0]                                sub_q, sub_n;
	logic [2:0]                                bit_q, bit_n;
	logic [i2cmbe_pkg::BYTE_W-1:0]             shift_q, shift_n;
	logic [i2cmbe_pkg::BYTE_W-1:0]             rdata_q, rdata_n;
	logic                                      scl_q, scl_n;
	logic                                      sda_q, sda_n;
	logic                                      ack_q, ack_n;
	logic                                      done_n;
	logic [i2cmbe_pkg::TICK_W-1:0]             ticks_q;
	logic [i2cmbe_pkg::TICK_W-1:0]             limit;
	logic                                      in_fire;
	logic                                      req_ok;
	logic                                      is_read;

	// Result register.
	logic                                      out_valid_q;
	logic                                      scl_out_q, sda_out_q, busy_out_q, done_out_q;
	logic                                      ack_out_q;
	logic [i2cmbe_pkg::BYTE_W-1:0]             rdata_out_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	// A zero phase length behaves as one tick.
	assign limit = (ticks_q == '0) ? i2cmbe_pkg::TICK_W'(1) : ticks_q;

	assign req_ok = (req_type >= 3'(i2cmbe_pkg::CMD_START))
		&& (req_type <= 3'(i2cmbe_pkg::CMD_READ_NACK));

	// Next state for one tick: accept a command, count the phase, sample and
	// open the next phase, or finish the command, when the count reaches its limit.
	always_comb begin
		cmd_n   = cmd_q;
		phase_n = phase_q;
		tick_n  = tick_q;
		sub_n   = sub_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		rdata_n = rdata_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		ack_n   = ack_q;
		done_n  = 1'b0;
		is_read = 1'b0;

		// Start a new command from idle, applying the levels of its first phase.
		if (cmd_q == i2cmbe_pkg::CMD_IDLE && req_ok) begin
			cmd_n   = i2cmbe_pkg::cmd_t'(req_type);
			phase_n = '0;
			tick_n  = '0;
			sub_n   = '0;
			bit_n   = i2cmbe_pkg::MSB_BIT;
			shift_n = (cmd_n == i2cmbe_pkg::CMD_WRITE) ? write_byte : '0;
			unique case (cmd_n)
				i2cmbe_pkg::CMD_START: begin
					sda_n = 1'b1;
					scl_n = 1'b1;
				end
				i2cmbe_pkg::CMD_STOP: sda_n = 1'b0;
				i2cmbe_pkg::CMD_WRITE: sda_n = write_byte[i2cmbe_pkg::MSB_BIT];
				default: begin
					sda_n = 1'b1;
					scl_n = 1'b1;
				end
			endcase
		end

		is_read = (cmd_n == i2cmbe_pkg::CMD_READ_ACK)
			|| (cmd_n == i2cmbe_pkg::CMD_READ_NACK);

		if (cmd_n != i2cmbe_pkg::CMD_IDLE) begin
			tick_n = tick_n + 1'b1;
			if (tick_n >= limit || tick_n == '0) begin
				// Sample SDA at the end of SCL-high phases.
				if (cmd_n == i2cmbe_pkg::CMD_WRITE
						&& phase_n == i2cmbe_pkg::PH_WR_ACK_SAMP) begin
					ack_n = sda_in;
				end
				if (is_read && phase_n < i2cmbe_pkg::PH_RD_ACK_DRV && !phase_n[0]) begin
					shift_n = {shift_n[i2cmbe_pkg::BYTE_W-2:0], sda_in};
				end
				tick_n  = '0;
				phase_n = phase_n + 1'b1;
				if (phase_n >= i2cmbe_pkg::phase_total(cmd_n)) begin
					// Command finished.
					if (cmd_n == i2cmbe_pkg::CMD_READ_ACK) begin
						sda_n = 1'b1;
					end
					if (is_read) begin
						rdata_n = shift_n;
					end
					cmd_n   = i2cmbe_pkg::CMD_IDLE;
					phase_n = '0;
					done_n  = 1'b1;
				end else begin
					// Open the next phase.
					unique case (cmd_n)
						i2cmbe_pkg::CMD_START: begin
							if (phase_n == 5'd1) begin
								sda_n = 1'b0;
							end else begin
								scl_n = 1'b0;
							end
						end
						i2cmbe_pkg::CMD_STOP: begin
							if (phase_n == 5'd1) begin
								scl_n = 1'b1;
							end else begin
								sda_n = 1'b1;
							end
						end
						i2cmbe_pkg::CMD_WRITE: begin
							if (phase_n < i2cmbe_pkg::PH_WR_ACK_REL) begin
								// Three phases per bit: data, SCL high, SCL low.
								if (sub_n == i2cmbe_pkg::SUB_LAST) begin
									sub_n = '0;
									bit_n = bit_n - 1'b1;
									sda_n = shift_n[bit_n];
								end else begin
									sub_n = sub_n + 1'b1;
									scl_n = (sub_n == 2'd1);
								end
							end else if (phase_n == i2cmbe_pkg::PH_WR_ACK_REL) begin
								sda_n = 1'b1;
							end else if (phase_n == i2cmbe_pkg::PH_WR_ACK_SAMP) begin
								scl_n = 1'b1;
							end else begin
								scl_n = 1'b0;
							end
						end
						default: begin
							if (phase_n < i2cmbe_pkg::PH_RD_ACK_DRV) begin
								// Two phases per bit: SCL high, SCL low.
								scl_n = !phase_n[0];
							end else if (phase_n == i2cmbe_pkg::PH_RD_ACK_DRV) begin
								sda_n = (cmd_n == i2cmbe_pkg::CMD_READ_NACK);
							end else if (phase_n == i2cmbe_pkg::PH_RD_ACK_CLK) begin
								scl_n = 1'b1;
							end else begin
								scl_n = 1'b0;
							end
						end
					endcase
				end
			end
		end
	end

	// Phase length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= i2cmbe_pkg::PHASE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			ticks_q <= phase_ticks;
		end
	end

	// Sequencer state advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cmbe_pkg::CMD_IDLE;
			phase_q <= '0;
			tick_q  <= '0;
			sub_q   <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			rdata_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b1;
		end else if (in_fire) begin
			cmd_q   <= cmd_n;
			phase_q <= phase_n;
			tick_q  <= tick_n;
			sub_q   <= sub_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			rdata_q <= rdata_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			ack_q   <= ack_n;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			scl_out_q   <= scl_n;
			sda_out_q   <= sda_n;
			busy_out_q  <= (cmd_n != i2cmbe_pkg::CMD_IDLE);
			done_out_q  <= done_n;
			rdata_out_q <= rdata_n;
			ack_out_q   <= ack_n;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_hiz   = scl_out_q;
	assign sda_hiz   = sda_out_q;
	assign busy_res  = busy_out_q;
	assign done_res  = done_out_q;
	assign read_byte = rdata_out_q;
	assign ack_bit   = ack_out_q;

endmodule

@@ dv/i2c_master_byte_engine_top_tb.sv @@
// Self-checking testbench for i2c_master_byte_engine_top: tick-by-tick bus sequencer
// predictor, directed table then random I2C transfers, random idling on both item channels.
// Depends on rtl/core/i2cmbe_pkg.sv and the top level RTL.
module i2c_master_byte_engine_top_tb;

	// Request codes the block does not know; it must stay idle on them.
	localparam logic [2:0] REQ_BAD_LO = 3'd6;
	localparam logic [2:0] REQ_BAD_HI = 3'd7;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned REPORT_MAX = 10;

	// Line levels and status shown on one tick.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rd;
		logic       ack;
	} bus_res_t;

	localparam bus_res_t LINES_AT_RESET = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1};

	// One row of the directed table; the row item is sent reps times in a row.
	typedef struct packed {
		logic       cfg_wr;
		logic [9:0] cfg_val;
		logic [2:0] req;
		logic [7:0] wbyte;
		logic       sda;
		logic [5:0] reps;
		logic       fixed;
		bus_res_t   res;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [9:0] phase_ticks;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] req_type;
	logic [7:0] write_byte;
	logic       sda_in;
	logic       out_valid;
	logic       out_ready;
	logic       scl_hiz;
	logic       sda_hiz;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_byte;
	logic       ack_bit;

	// Predicted sequencer state.
	logic [9:0]       tick_limit_cfg;
	i2cmbe_pkg::cmd_t seq_cmd;
	logic [4:0]       seq_phase;
	logic [9:0]       seq_cnt;
	logic [7:0]       seq_shift;
	logic             seq_scl;
	logic             seq_sda;
	logic             seq_ack;
	logic [7:0]       seq_rd;

	bus_res_t   expected_lines[$];
	stim_row_t  plan[$];
	int         fault_cnt = 0;
	int         results_seen = 0;
	int         items_sent = 0;
	int         xfer_left = -1;

	always #10 clk = ~clk;

	i2c_master_byte_engine_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.phase_ticks(phase_ticks),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.write_byte (write_byte),
		.sda_in     (sda_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.scl_hiz    (scl_hiz),
		.sda_hiz    (sda_hiz),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_byte  (read_byte),
		.ack_bit    (ack_bit)
	);

	// Line changes at the opening of phase p of the running command.
	function automatic void open_phase(input logic [4:0] p);
		int b;
		case (seq_cmd)
			i2cmbe_pkg::CMD_START: begin
				if (p == 0) begin
					seq_sda = 1'b1;
					seq_scl = 1'b1;
				end else if (p == 1) seq_sda = 1'b0;
				else seq_scl = 1'b0;
			end
			i2cmbe_pkg::CMD_STOP: begin
				if (p == 0) seq_sda = 1'b0;
				else if (p == 1) seq_scl = 1'b1;
				else seq_sda = 1'b1;
			end
			i2cmbe_pkg::CMD_WRITE: begin
				if (p < i2cmbe_pkg::PH_WR_ACK_REL) begin
					b = 7 - int'(p / 3);
					if (p % 3 == 0) seq_sda = seq_shift[b];
					else if (p % 3 == 1) seq_scl = 1'b1;
					else seq_scl = 1'b0;
				end else if (p == i2cmbe_pkg::PH_WR_ACK_REL) seq_sda = 1'b1;
				else if (p == i2cmbe_pkg::PH_WR_ACK_SAMP) seq_scl = 1'b1;
				else seq_scl = 1'b0;
			end
			default: begin
				if (p < i2cmbe_pkg::PH_RD_ACK_DRV) begin
					if (p[0] == 1'b0) begin
						if (p == 0) seq_sda = 1'b1;
						seq_scl = 1'b1;
					end else seq_scl = 1'b0;
				end else if (p == i2cmbe_pkg::PH_RD_ACK_DRV)
					seq_sda = (seq_cmd == i2cmbe_pkg::CMD_READ_NACK);
				else if (p == i2cmbe_pkg::PH_RD_ACK_CLK) seq_scl = 1'b1;
				else seq_scl = 1'b0;
			end
		endcase
	endfunction

	// Advance the sequencer by one tick and return the levels it shows.
	function automatic bus_res_t seq_tick(input logic [2:0] rq, input logic [7:0] wb,
			input logic sd);
		logic [9:0] lim;
		logic [4:0] total;
		logic       fin;
		logic       rd_cmd;
		lim = (tick_limit_cfg == 10'd0) ? 10'd1 : tick_limit_cfg;
		fin = 1'b0;
		if (seq_cmd == i2cmbe_pkg::CMD_IDLE && rq >= i2cmbe_pkg::CMD_START
				&& rq <= i2cmbe_pkg::CMD_READ_NACK) begin
			seq_cmd = i2cmbe_pkg::cmd_t'(rq);
			seq_phase = '0;
			seq_cnt = '0;
			seq_shift = (seq_cmd == i2cmbe_pkg::CMD_WRITE) ? wb : 8'h00;
			open_phase(seq_phase);
		end
		if (seq_cmd != i2cmbe_pkg::CMD_IDLE) begin
			seq_cnt = seq_cnt + 10'd1;
			if (seq_cnt >= lim || seq_cnt == 10'd0) begin
				rd_cmd = (seq_cmd == i2cmbe_pkg::CMD_READ_ACK)
					|| (seq_cmd == i2cmbe_pkg::CMD_READ_NACK);
				// Sample SDA at the end of the SCL-high phases.
				if (seq_cmd == i2cmbe_pkg::CMD_WRITE && seq_phase == i2cmbe_pkg::PH_WR_ACK_SAMP)
					seq_ack = sd;
				if (rd_cmd && seq_phase < i2cmbe_pkg::PH_RD_ACK_DRV && seq_phase[0] == 1'b0)
					seq_shift = {seq_shift[6:0], sd};
				seq_cnt = '0;
				seq_phase = seq_phase + 5'd1;
				if (seq_cmd == i2cmbe_pkg::CMD_START || seq_cmd == i2cmbe_pkg::CMD_STOP)
					total = i2cmbe_pkg::PH_TOTAL_SHORT;
				else if (seq_cmd == i2cmbe_pkg::CMD_WRITE) total = i2cmbe_pkg::PH_TOTAL_WRITE;
				else total = i2cmbe_pkg::PH_TOTAL_READ;
				if (seq_phase >= total) begin
					if (seq_cmd == i2cmbe_pkg::CMD_READ_ACK) seq_sda = 1'b1;
					if (rd_cmd) seq_rd = seq_shift;
					seq_cmd = i2cmbe_pkg::CMD_IDLE;
					seq_phase = '0;
					fin = 1'b1;
				end else begin
					open_phase(seq_phase);
				end
			end
		end
		return '{seq_scl, seq_sda, seq_cmd != i2cmbe_pkg::CMD_IDLE, fin, seq_rd, seq_ack};
	endfunction

	// Idle length: mostly none or short, a few long, none at all in calm stretches.
	function automatic int pick_gap(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Next command of a bus transfer: start, a few bytes or restarts, then stop.
	function automatic logic [2:0] next_bus_cmd();
		int unsigned r;
		if (xfer_left < 0) begin
			xfer_left = $urandom_range(1, 4);
			return i2cmbe_pkg::CMD_START;
		end
		if (xfer_left == 0) begin
			xfer_left = -1;
			return i2cmbe_pkg::CMD_STOP;
		end
		xfer_left--;
		r = $urandom_range(0, 99);
		if (r < 45) return i2cmbe_pkg::CMD_WRITE;
		if (r < 70) return i2cmbe_pkg::CMD_READ_ACK;
		if (r < 92) return i2cmbe_pkg::CMD_READ_NACK;
		return i2cmbe_pkg::CMD_START;
	endfunction

	// Offer one tick item and record what it must produce once accepted.
	task automatic offer_item(input logic [2:0] rq, input logic [7:0] wb, input logic sd,
			input logic use_fixed, input bus_res_t fixed_res);
		int gap;
		bus_res_t want;
		gap = pick_gap(((items_sent / 64) % 4) == 3);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		write_byte <= wb;
		sda_in <= sd;
		do @(posedge clk); while (!in_ready);
		want = seq_tick(rq, wb, sd);
		expected_lines.push_back(use_fixed ? fixed_res : want);
		items_sent++;
	endtask

	// Write phase_ticks once every outstanding result has come back.
	task automatic write_phase_ticks(input logic [9:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_lines.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_valid <= 1'b1;
		phase_ticks <= v;
		do @(posedge clk); while (!cfg_ready);
		tick_limit_cfg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result checker: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		bus_res_t got;
		bus_res_t want;
		if (out_valid && out_ready) begin
			got = '{scl_hiz, sda_hiz, busy_res, done_res, read_byte, ack_bit};
			results_seen++;
			if (expected_lines.size() == 0) begin
				if (fault_cnt < REPORT_MAX)
					$display("result with nothing expected: %b %b %b %b %h %b",
						got.scl, got.sda, got.busy, got.done, got.rd, got.ack);
				fault_cnt++;
			end else begin
				want = expected_lines.pop_front();
				if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
						got.done !== want.done || got.rd !== want.rd || got.ack !== want.ack) begin
					if (fault_cnt < REPORT_MAX) begin
						$display("mismatch at result %0d:", results_seen);
						$display("  exp scl=%b sda=%b busy=%b done=%b rd=%h ack=%b",
							want.scl, want.sda, want.busy, want.done, want.rd, want.ack);
						$display("  got scl=%b sda=%b busy=%b done=%b rd=%h ack=%b",
							got.scl, got.sda, got.busy, got.done, got.rd, got.ack);
					end
					fault_cnt++;
				end
			end
		end
	end

	// Receiver side: random stalls, calm stretches, and one long hold-off.
	initial begin : sink_ctrl
		int  stall;
		bit  held;
		stall = 0;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (!held && results_seen >= 400) begin
					stall = LONG_HOLD;
					held = 1'b1;
				end else begin
					stall = pick_gap(((results_seen / 80) % 4) == 1);
				end
			end
		end
	end

	// Run limit.
	initial begin
		#10_000_000;
		$display("[i2c_master_byte_engine_top] ERROR");
		$finish;
	end

	// Stimulus: directed table, then random transfers over several phase lengths.
	initial begin : stim
		logic [9:0] seg_ticks [0:9];
		logic [2:0] rq;
		int unsigned r;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		phase_ticks = '0;
		in_valid = 1'b0;
		req_type = i2cmbe_pkg::CMD_IDLE;
		write_byte = '0;
		sda_in = 1'b1;

		tick_limit_cfg = i2cmbe_pkg::PHASE_TICKS_RST;
		seq_cmd = i2cmbe_pkg::CMD_IDLE;
		seq_phase = '0;
		seq_cnt = '0;
		seq_shift = '0;
		seq_scl = 1'b1;
		seq_sda = 1'b1;
		seq_ack = 1'b1;
		seq_rd = '0;

		// Reset values show on idle ticks and unknown codes; start at the reset
		// phase length with start requests repeated while busy; then a zero length,
		// stop, all-ones and all-zeros writes; length one: write A5, ACK and NACK reads.
		plan.push_back('{1'b0, 10'd0, i2cmbe_pkg::CMD_IDLE, 8'h00, 1'b1, 6'd1, 1'b1,
			LINES_AT_RESET});
		plan.push_back('{1'b0, 10'd0, REQ_BAD_LO, 8'hFF, 1'b0, 6'd1, 1'b1, LINES_AT_RESET});
		plan.push_back('{1'b0, 10'd0, REQ_BAD_HI, 8'h00, 1'b1, 6'd1, 1'b1, LINES_AT_RESET});
		plan.push_back('{1'b0, 10'd0, i2cmbe_pkg::CMD_START, 8'h00, 1'b1, 6'd15, 1'b0,
			LINES_AT_RESET});
		plan.push_back('{1'b1, 10'd0, i2cmbe_pkg::CMD_STOP, 8'h00, 1'b1, 6'd3, 1'b0,
			LINES_AT_RESET});
		plan.push_back('{1'b0, 10'd0, i2cmbe_pkg::CMD_WRITE, 8'hFF, 1'b0, 6'd27, 1'b0,
			LINES_AT_RESET});
		plan.push_back('{1'b0, 10'd0, i2cmbe_pkg::CMD_WRITE, 8'h00, 1'b1, 6'd27, 1'b0,
			LINES_AT_RESET});
		plan.push_back('{1'b1, 10'd1, i2cmbe_pkg::CMD_WRITE, 8'hA5, 1'b0, 6'd27, 1'b0,
			LINES_AT_RESET});
		plan.push_back('{1'b0, 10'd0, i2cmbe_pkg::CMD_READ_ACK, 8'h00, 1'b1, 6'd19, 1'b0,
			LINES_AT_RESET});
		plan.push_back('{1'b0, 10'd0, i2cmbe_pkg::CMD_READ_NACK, 8'hFF, 1'b0, 6'd19, 1'b0,
			LINES_AT_RESET});

		// Phase lengths for the random part: extremes, small values, and a long one
		// followed by a short one so that a running phase gets cut.
		seg_ticks = '{10'd1, 10'd3, 10'd1023, 10'd2, 10'd200, 10'd4, 10'd0, 10'd6,
			10'd1, 10'd2};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].cfg_wr) write_phase_ticks(plan[i].cfg_val);
			repeat (plan[i].reps)
				offer_item(plan[i].req, plan[i].wbyte, plan[i].sda, plan[i].fixed,
					plan[i].res);
		end

		// Random part: bus transfers when idle, noise requests while busy.
		foreach (seg_ticks[s]) begin
			write_phase_ticks(seg_ticks[s]);
			repeat (100) begin
				r = $urandom_range(0, 99);
				if (seq_cmd != i2cmbe_pkg::CMD_IDLE) rq = 3'($urandom_range(0, 7));
				else if (r < 75) rq = next_bus_cmd();
				else if (r < 90) rq = i2cmbe_pkg::CMD_IDLE;
				else if (r < 95) rq = REQ_BAD_LO;
				else rq = REQ_BAD_HI;
				offer_item(rq, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
					LINES_AT_RESET);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fault_cnt == 0 && expected_lines.size() == 0) begin
			$display("[i2c_master_byte_engine_top] OK");
		end else begin
			$display("[i2c_master_byte_engine_top] ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/i2cmbe_pkg.sv
rtl/core/i2c_master_byte_engine_top.sv
dv/i2c_master_byte_engine_top_tb.sv
